FILE: hw/rtl/csa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types and constants for the column scatter-accumulate engine.
// ----------------------------------------------------------------------------
package csa_pkg;

    localparam int ROW_W   = 6;
    localparam int COL_W   = 8;
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 9;
    localparam int ROWS_W  = 7;
    localparam int COLS_W  = 9;
    localparam logic [ROWS_W-1:0] MAX_ROWS = 7'd64;
    localparam logic [COLS_W-1:0] MAX_COLS = 9'd256;
    localparam int ADD_LAT = 3;

    localparam logic [0:0] REG_ROWS = 1'b0;
    localparam logic [0:0] REG_COLS = 1'b1;

    localparam logic [1:0] KIND_ACC   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BAD_SUB = 2'd1;
    localparam logic [1:0] STAT_BAD_ROW = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic signed [31:0] subscript;
        logic [ROW_W-1:0]  row;
        logic [VAL_W-1:0]  value;
        logic              last;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [1:0]       status;
        logic             batch_done;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_EXEC,
        S_ADD,
        S_WRITE,
        S_DONE,
        S_WAIT
    } t_state;

    typedef struct packed {
        logic load;
        logic skip;
        logic mem_rd;
        logic take_rd;
        logic wr_val;
        logic wr_sum;
    } t_cmd;

    typedef struct packed {
        logic       skip;
        logic [1:0] kind;
    } t_stat;

endpackage

FILE: hw/rtl/csa_fadd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_fadd
// Four-stage single-precision adder, round to nearest even.
// ----------------------------------------------------------------------------
module csa_fadd (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        n = 5'd26;
        for (int i = 0; i < 27; i++) begin
            if (v[i]) begin
                n = 5'(26 - i);
            end
        end
        return n;
    endfunction

    // stage 1: specials, swap, align
    logic        a_nan, b_nan, a_inf, b_inf, swap;
    logic [31:0] x, y;
    logic [7:0]  ex, ey, d;
    logic [4:0]  dc;
    logic [23:0] mx, my;
    logic [53:0] wide;
    logic        n_spec;
    logic [31:0] n_sval;

    logic        r1_spec, r1_sx, r1_sub;
    logic [31:0] r1_sval;
    logic [7:0]  r1_ex;
    logic [26:0] r1_mx, r1_my;

    always_comb begin
        a_nan = (&i_a[30:23]) & (|i_a[22:0]);
        b_nan = (&i_b[30:23]) & (|i_b[22:0]);
        a_inf = (&i_a[30:23]) & ~(|i_a[22:0]);
        b_inf = (&i_b[30:23]) & ~(|i_b[22:0]);
        n_spec = 1'b1;
        n_sval = 32'hFFC0_0000;
        if (a_nan) begin
            n_sval = i_a | 32'h0040_0000;
        end else if (b_nan) begin
            n_sval = i_b | 32'h0040_0000;
        end else if (a_inf && b_inf && (i_a[31] != i_b[31])) begin
            n_sval = 32'hFFC0_0000;
        end else if (a_inf) begin
            n_sval = i_a;
        end else if (b_inf) begin
            n_sval = i_b;
        end else begin
            n_spec = 1'b0;
        end
        swap = i_a[30:0] < i_b[30:0];
        x    = swap ? i_b : i_a;
        y    = swap ? i_a : i_b;
        ex   = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey   = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        mx   = {x[30:23] != 8'd0, x[22:0]};
        my   = {y[30:23] != 8'd0, y[22:0]};
        d    = ex - ey;
        dc   = (d > 8'd27) ? 5'd27 : d[4:0];
        wide = {my, 3'b000, 27'd0} >> dc;
    end

    always_ff @(posedge i_clk) begin
        r1_spec <= n_spec;
        r1_sval <= n_sval;
        r1_sx   <= x[31];
        r1_sub  <= x[31] ^ y[31];
        r1_ex   <= ex;
        r1_mx   <= {mx, 3'b000};
        r1_my   <= {wide[53:28], wide[27] | (|wide[26:0])};
    end

    // stage 2: add or subtract magnitudes
    logic [27:0] n_sum;
    logic        r2_spec, r2_sign;
    logic [31:0] r2_sval;
    logic [7:0]  r2_ex;
    logic [27:0] r2_sum;

    always_comb begin
        n_sum = r1_sub ? ({1'b0, r1_mx} - {1'b0, r1_my}) : ({1'b0, r1_mx} + {1'b0, r1_my});
    end

    always_ff @(posedge i_clk) begin
        r2_spec <= r1_spec;
        r2_sval <= r1_sval;
        r2_ex   <= r1_ex;
        r2_sum  <= n_sum;
        r2_sign <= (n_sum == 28'd0) ? (r1_sx & ~r1_sub) : r1_sx;
    end

    // stage 3: normalize
    logic [4:0]  lz, sh;
    logic [7:0]  lim;
    logic [26:0] n_norm;
    logic [8:0]  n_e;
    logic        r3_spec, r3_sign;
    logic [31:0] r3_sval;
    logic [26:0] r3_norm;
    logic [8:0]  r3_e;

    always_comb begin
        lz  = lzc27(r2_sum[26:0]);
        lim = r2_ex - 8'd1;
        sh  = ({3'b000, lz} < lim) ? lz : lim[4:0];
        if (r2_sum[27]) begin
            n_norm = {r2_sum[27:2], r2_sum[1] | r2_sum[0]};
            n_e    = {1'b0, r2_ex} + 9'd1;
        end else begin
            n_norm = r2_sum[26:0] << sh;
            n_e    = {1'b0, r2_ex} - {4'd0, sh};
        end
    end

    always_ff @(posedge i_clk) begin
        r3_spec <= r2_spec;
        r3_sval <= r2_sval;
        r3_sign <= r2_sign;
        r3_norm <= n_norm;
        r3_e    <= n_e;
    end

    // stage 4: round and pack
    logic        rup;
    logic [7:0]  efield;
    logic [30:0] packed_v;
    logic [31:0] n_y;
    logic [31:0] r4_y;

    always_comb begin
        rup      = r3_norm[2] & (r3_norm[1] | r3_norm[0] | r3_norm[3]);
        efield   = r3_norm[26] ? r3_e[7:0] : 8'd0;
        packed_v = {efield, r3_norm[25:3]} + {30'd0, rup};
        if (r3_spec) begin
            n_y = r3_sval;
        end else if (r3_e >= 9'd255) begin
            n_y = {r3_sign, 8'hFF, 23'd0};
        end else begin
            n_y = {r3_sign, packed_v};
        end
    end

    always_ff @(posedge i_clk) begin
        r4_y <= n_y;
    end

    assign o_y = r4_y;

endmodule

FILE: hw/rtl/csa_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_dpath
// Accumulator store, range checks, adder and result register.
// ----------------------------------------------------------------------------
module csa_dpath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [0:0]             i_cfg_idx,
    input  logic [csa_pkg::CFG_W-1:0] i_cfg_data,
    input  csa_pkg::t_in_item      i_item,
    input  csa_pkg::t_cmd          i_cmd,
    output csa_pkg::t_stat         o_stat,
    output csa_pkg::t_out_item     o_item
);

    logic [csa_pkg::VAL_W-1:0] r_mem [csa_pkg::DEPTH];
    csa_pkg::t_in_item         r_item;
    csa_pkg::t_out_item        r_out;
    logic [csa_pkg::VAL_W-1:0] r_rdata;
    logic [csa_pkg::ROWS_W-1:0] r_rows;
    logic [csa_pkg::COLS_W-1:0] r_cols;

    logic [csa_pkg::ROWS_W-1:0] row_lim;
    logic [csa_pkg::COLS_W-1:0] col_lim;
    logic                       bad_sub, bad_row, is_nop;
    logic [csa_pkg::COL_W-1:0]  col;
    logic [csa_pkg::ADDR_W-1:0] addr;
    logic [csa_pkg::VAL_W-1:0]  sum;

    always_comb begin
        row_lim = (r_rows > csa_pkg::MAX_ROWS) ? csa_pkg::MAX_ROWS : r_rows;
        col_lim = (r_cols > csa_pkg::MAX_COLS) ? csa_pkg::MAX_COLS : r_cols;
        is_nop  = r_item.kind == csa_pkg::KIND_NOP;
        bad_sub = r_item.subscript[31] || (r_item.subscript == 32'sd0) ||
                  (|r_item.subscript[30:9]) || (r_item.subscript[8:0] > col_lim);
        bad_row = {1'b0, r_item.row} >= row_lim;
        col     = r_item.subscript[csa_pkg::COL_W-1:0] - 8'd1;
        addr    = {col, r_item.row};
        o_stat.skip = is_nop || bad_sub || bad_row;
        o_stat.kind = r_item.kind;
    end

    csa_fadd u_fadd (
        .i_clk (i_clk),
        .i_a   (r_rdata),
        .i_b   (r_item.value),
        .o_y   (sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= csa_pkg::MAX_ROWS;
            r_cols <= csa_pkg::MAX_COLS;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == csa_pkg::REG_ROWS) begin
                r_rows <= i_cfg_data[csa_pkg::ROWS_W-1:0];
            end else begin
                r_cols <= i_cfg_data[csa_pkg::COLS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[addr];
        end
        if (i_cmd.wr_val) begin
            r_mem[addr] <= r_item.value;
        end else if (i_cmd.wr_sum) begin
            r_mem[addr] <= sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.skip) begin
            r_out.read_value <= '0;
            r_out.status     <= is_nop ? csa_pkg::STAT_OK :
                                bad_sub ? csa_pkg::STAT_BAD_SUB : csa_pkg::STAT_BAD_ROW;
            r_out.batch_done <= r_item.last;
        end else if (i_cmd.take_rd || i_cmd.wr_val || i_cmd.wr_sum) begin
            r_out.read_value <= i_cmd.take_rd ? r_rdata :
                                i_cmd.wr_val ? r_item.value : sum;
            r_out.status     <= csa_pkg::STAT_OK;
            r_out.batch_done <= r_item.last;
        end
    end

    assign o_item = r_out;

endmodule

FILE: hw/rtl/csa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_ctrl
// Sequencer: check, read entry, add, write back, hand off the result.
// ----------------------------------------------------------------------------
module csa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  csa_pkg::t_stat i_stat,
    output csa_pkg::t_cmd  o_cmd
);

    csa_pkg::t_state r_state, n_state;
    logic [1:0]      r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csa_pkg::S_IDLE;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            csa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = csa_pkg::S_CHECK;
                end
            end
            csa_pkg::S_CHECK: begin
                n_state = i_stat.skip ? csa_pkg::S_DONE : csa_pkg::S_EXEC;
            end
            csa_pkg::S_EXEC: begin
                n_cnt   = 2'd0;
                n_state = (i_stat.kind == csa_pkg::KIND_ACC) ? csa_pkg::S_ADD
                                                             : csa_pkg::S_DONE;
            end
            csa_pkg::S_ADD: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'(csa_pkg::ADD_LAT - 1)) begin
                    n_state = csa_pkg::S_WRITE;
                end
            end
            csa_pkg::S_WRITE: begin
                n_state = csa_pkg::S_DONE;
            end
            csa_pkg::S_DONE: begin
                if (i_out_ready) begin
                    n_state = i_in_valid ? csa_pkg::S_CHECK : csa_pkg::S_IDLE;
                end else if (i_in_valid) begin
                    n_state = csa_pkg::S_WAIT;
                end
            end
            csa_pkg::S_WAIT: begin
                if (i_out_ready) begin
                    n_state = csa_pkg::S_CHECK;
                end
            end
            default: begin
                n_state = csa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            csa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            csa_pkg::S_CHECK: begin
                o_cmd.skip   = i_stat.skip;
                o_cmd.mem_rd = ~i_stat.skip;
            end
            csa_pkg::S_EXEC: begin
                o_cmd.take_rd = i_stat.kind == csa_pkg::KIND_READ;
                o_cmd.wr_val  = i_stat.kind == csa_pkg::KIND_WRITE;
            end
            csa_pkg::S_ADD: begin
            end
            csa_pkg::S_WRITE: begin
                o_cmd.wr_sum = 1'b1;
            end
            csa_pkg::S_DONE: begin
                o_out_valid = 1'b1;
                o_in_ready  = 1'b1;
                o_cmd.load  = i_in_valid;
            end
            csa_pkg::S_WAIT: begin
                o_out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: hw/rtl/column_scatter_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_scatter_accumulate
// Scatter-add of single-precision values into a 256 x 64 accumulator store.
//
//   channel | signals                                  | direction
//   in      | i_in_valid, o_in_ready, i_in_item        | item in
//   out     | o_out_valid, i_out_ready, o_out_item     | result out
//   cfg     | i_cfg_we, i_cfg_idx, i_cfg_data          | register write
//
// Skipped items go from check to done; reads and writes pass through exec;
// accumulates read the entry, wait for the four-stage adder and write back.
// One item is processed at a time; the next item is taken while the result
// waits and starts once the result is taken.
// A stalled output lets one more item in, then holds the input.
// Reset clears control and sets the rows and cols registers to 64 and 256;
// the store has no reset and must be written before use.
// ----------------------------------------------------------------------------
module column_scatter_accumulate (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  csa_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output csa_pkg::t_out_item        o_out_item,
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_idx,
    input  logic [csa_pkg::CFG_W-1:0] i_cfg_data
);

    csa_pkg::t_cmd  cmd;
    csa_pkg::t_stat stat;

    csa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    csa_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_item),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_item     (o_out_item)
    );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for column_scatter_accumulate. A directed table of
// items, then random traffic over several register settings, is checked
// against a bit-accurate single-precision predictor of the accumulator store.
// ----------------------------------------------------------------------------
module tb_top;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       in_valid;
    logic                       o_in_ready;
    csa_pkg::t_in_item          in_item;
    logic                       o_out_valid;
    logic                       out_ready;
    csa_pkg::t_out_item         o_out_item;
    logic                       cfg_we;
    logic [0:0]                 cfg_idx;
    logic [csa_pkg::CFG_W-1:0]  cfg_data;

    column_scatter_accumulate uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    typedef struct {
        csa_pkg::t_in_item  it;
        bit                 typed;
        csa_pkg::t_out_item res;
    } t_dir_row;

    logic [31:0]          acc_store [csa_pkg::DEPTH];
    bit                   entry_set [csa_pkg::DEPTH];
    int unsigned          rows_reg;
    int unsigned          cols_reg;
    csa_pkg::t_out_item   pending_q[$];
    t_dir_row             dir_q[$];
    int                   mismatch_cnt;
    bit                   idle_en;
    bit                   long_hold_req;
    int                   hold_cnt;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3ms;
        $display("[column_scatter_accumulate] ERROR");
        $finish;
    end

    function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
        logic        sa, sb, st;
        int          xa, xb, xt, d, e;
        logic [27:0] ma, mb, mt, m;
        logic [24:0] mant;
        sa = a[31];
        sb = b[31];
        if (a[30:23] == 8'hff && a[22:0] != 0) return a | 32'h0040_0000;
        if (b[30:23] == 8'hff && b[22:0] != 0) return b | 32'h0040_0000;
        if (a[30:23] == 8'hff) begin
            if (b[30:23] == 8'hff && sa != sb) return 32'hffc0_0000;
            return a;
        end
        if (b[30:23] == 8'hff) return b;
        ma = {1'b0, a[30:23] != 0, a[22:0], 3'b000};
        mb = {1'b0, b[30:23] != 0, b[22:0], 3'b000};
        xa = (a[30:23] == 0) ? 1 : a[30:23];
        xb = (b[30:23] == 0) ? 1 : b[30:23];
        if (xb > xa || (xb == xa && mb > ma)) begin
            st = sa; sa = sb; sb = st;
            xt = xa; xa = xb; xb = xt;
            mt = ma; ma = mb; mb = mt;
        end
        d = xa - xb;
        if (d >= 27) mb = 28'(mb != 0);
        else mb = (mb >> d) | 28'((mb & ((28'd1 << d) - 1)) != 0);
        e = xa;
        m = (sa == sb) ? ma + mb : ma - mb;
        if (m == 0) return (sa == sb) ? {sa, 31'b0} : 32'b0;
        if (m[27]) begin
            m = (m >> 1) | 28'(m[0]);
            e++;
        end
        while (!m[26] && e > 1) begin
            m = m << 1;
            e--;
        end
        mant = {1'b0, m[26:3]};
        if (m[2] && (m[1:0] != 0 || mant[0])) mant++;
        if (mant[24]) begin
            mant = mant >> 1;
            e++;
        end
        if (e >= 255) return {sa, 8'hff, 23'b0};
        return {sa, mant[23] ? e[7:0] : 8'd0, mant[22:0]};
    endfunction

    function automatic int unsigned row_limit();
        return (rows_reg > 64) ? 64 : rows_reg;
    endfunction

    function automatic int unsigned col_limit();
        return (cols_reg > 256) ? 256 : cols_reg;
    endfunction

    function automatic csa_pkg::t_out_item scatter_add(csa_pkg::t_in_item it);
        csa_pkg::t_out_item r;
        int unsigned        idx;
        r = '0;
        r.batch_done = it.last;
        if (it.kind == csa_pkg::KIND_NOP) begin
            r.status = csa_pkg::STAT_OK;
        end else if (it.subscript < 1 || it.subscript > col_limit()) begin
            r.status = csa_pkg::STAT_BAD_SUB;
        end else if (it.row >= row_limit()) begin
            r.status = csa_pkg::STAT_BAD_ROW;
        end else begin
            idx = (it.subscript - 1) * 64 + it.row;
            if (it.kind == csa_pkg::KIND_ACC) acc_store[idx] = fadd(acc_store[idx], it.value);
            else if (it.kind == csa_pkg::KIND_WRITE) acc_store[idx] = it.value;
            entry_set[idx] = 1'b1;
            r.read_value = acc_store[idx];
            r.status = csa_pkg::STAT_OK;
        end
        return r;
    endfunction

    task automatic send_item(csa_pkg::t_in_item it, bit typed, csa_pkg::t_out_item res);
        csa_pkg::t_out_item p;
        if (idle_en && $urandom_range(99) < 22) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        p = scatter_add(it);
        pending_q.push_back(typed ? res : p);
    endtask

    task automatic write_reg(logic [0:0] idx, int unsigned val);
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[csa_pkg::CFG_W-1:0];
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == csa_pkg::REG_ROWS) rows_reg = val & 'h7f;
        else cols_reg = val & 'h1ff;
    endtask

    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 3) return 32'h7f80_0000;
        if (sel < 5) return 32'hff80_0000;
        if (sel < 7) return 32'h7fc0_0000 | $urandom_range(255);
        if (sel < 10) return {1'($urandom_range(1)), 31'(1 + $urandom_range(1000))};
        if (sel < 12) return {1'($urandom_range(1)), 31'h7f7f_ffff};
        if (sel < 14) return {1'($urandom_range(1)), 31'b0};
        if (sel < 35) return $urandom;
        return {1'($urandom_range(1)), 8'($urandom_range(135, 118)), 23'($urandom)};
    endfunction

    function automatic csa_pkg::t_in_item make_item();
        csa_pkg::t_in_item it;
        int                sel;
        int unsigned       cl, rl, hot;
        cl = col_limit();
        rl = row_limit();
        sel = $urandom_range(99);
        it.kind  = (sel < 55) ? csa_pkg::KIND_ACC : (sel < 70) ? csa_pkg::KIND_READ :
                   (sel < 92) ? csa_pkg::KIND_WRITE : csa_pkg::KIND_NOP;
        it.value = pick_value();
        it.last  = ($urandom_range(7) == 0);
        sel = $urandom_range(99);
        hot = (cl > 6) ? 6 : cl;
        if (sel < 80 && cl > 0) it.subscript = (sel < 50) ? $urandom_range(hot, 1) :
                                               $urandom_range(cl, 1);
        else if (sel < 90) it.subscript = cl + $urandom_range(2);
        else it.subscript = $urandom;
        if ($urandom_range(99) < 75 && rl > 0)
            it.row = 6'($urandom_range(rl - 1 < 7 ? rl - 1 : 7));
        else it.row = 6'($urandom);
        if ((it.kind == csa_pkg::KIND_ACC || it.kind == csa_pkg::KIND_READ) &&
            it.subscript >= 1 && it.subscript <= cl && it.row < rl &&
            !entry_set[(it.subscript - 1) * 64 + it.row]) begin
            it.kind = csa_pkg::KIND_WRITE;
        end
        return it;
    endfunction

    task automatic add_row(logic [1:0] k, int s, logic [5:0] r, logic [31:0] v, bit l,
                           bit typed, logic [31:0] rv, logic [1:0] st);
        t_dir_row d;
        d.it  = '{kind: k, subscript: s, row: r, value: v, last: l};
        d.typed = typed;
        d.res = '{read_value: rv, status: st, batch_done: l};
        dir_q.push_back(d);
    endtask

    initial begin
        csa_pkg::t_out_item dummy;
        int                 rows_set [6];
        int                 cols_set [6];
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_idx = csa_pkg::REG_ROWS;
        cfg_data = '0;
        idle_en = 1'b1;
        long_hold_req = 1'b0;
        mismatch_cnt = 0;
        rows_reg = 64;
        cols_reg = 256;
        dummy = '0;
        rows_set = '{64, 1, 0, 127, 17, 64};
        cols_set = '{256, 1, 0, 511, 40, 256};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(csa_pkg::KIND_WRITE, 1, 0, 32'h3f80_0000, 0, 1, 32'h3f80_0000,
                csa_pkg::STAT_OK);
        add_row(csa_pkg::KIND_ACC, 1, 0, 32'h3f80_0000, 0, 0, 0, csa_pkg::STAT_OK);
        add_row(csa_pkg::KIND_READ, 1, 0, 32'h0, 0, 0, 0, csa_pkg::STAT_OK);
        add_row(csa_pkg::KIND_WRITE, 256, 63, 32'h7f7f_ffff, 0, 1, 32'h7f7f_ffff,
                csa_pkg::STAT_OK);
        add_row(csa_pkg::KIND_ACC, 256, 63, 32'h7f7f_ffff, 0, 0, 0, csa_pkg::STAT_OK);
        add_row(csa_pkg::KIND_WRITE, 256, 62, 32'h0000_0001, 0, 1, 32'h0000_0001,
                csa_pkg::STAT_OK);
        add_row(csa_pkg::KIND_ACC, 256, 62, 32'h8000_0001, 0, 0, 0, csa_pkg::STAT_OK);
        add_row(csa_pkg::KIND_WRITE, 2, 5, 32'h7fc0_0001, 0, 1, 32'h7fc0_0001,
                csa_pkg::STAT_OK);
        add_row(csa_pkg::KIND_ACC, 2, 5, 32'h3f80_0000, 0, 0, 0, csa_pkg::STAT_OK);
        add_row(csa_pkg::KIND_WRITE, 3, 0, 32'h7f80_0000, 0, 1, 32'h7f80_0000,
                csa_pkg::STAT_OK);
        add_row(csa_pkg::KIND_ACC, 3, 0, 32'hff80_0000, 0, 0, 0, csa_pkg::STAT_OK);
        add_row(csa_pkg::KIND_ACC, 0, 0, 32'h3f80_0000, 0, 1, 0, csa_pkg::STAT_BAD_SUB);
        add_row(csa_pkg::KIND_ACC, -1, 0, 32'h3f80_0000, 0, 1, 0, csa_pkg::STAT_BAD_SUB);
        add_row(csa_pkg::KIND_READ, 32'h8000_0000, 0, 0, 0, 1, 0, csa_pkg::STAT_BAD_SUB);
        add_row(csa_pkg::KIND_WRITE, 257, 0, 32'hffff_ffff, 1, 1, 0, csa_pkg::STAT_BAD_SUB);
        add_row(csa_pkg::KIND_READ, 32'h7fff_ffff, 63, 0, 0, 1, 0, csa_pkg::STAT_BAD_SUB);
        add_row(csa_pkg::KIND_NOP, 5, 9, 32'h1234_5678, 1, 1, 0, csa_pkg::STAT_OK);
        add_row(csa_pkg::KIND_WRITE, 1, 1, 32'hffff_ffff, 1, 1, 32'hffff_ffff,
                csa_pkg::STAT_OK);
        add_row(csa_pkg::KIND_ACC, 1, 1, 32'h0, 0, 0, 0, csa_pkg::STAT_OK);
        add_row(csa_pkg::KIND_WRITE, 4, 7, 32'h8000_0000, 0, 1, 32'h8000_0000,
                csa_pkg::STAT_OK);
        add_row(csa_pkg::KIND_ACC, 4, 7, 32'h8000_0000, 1, 0, 0, csa_pkg::STAT_OK);
        foreach (dir_q[i]) send_item(dir_q[i].it, dir_q[i].typed, dir_q[i].res);

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(csa_pkg::REG_ROWS, rows_set[ph]);
            write_reg(csa_pkg::REG_COLS, cols_set[ph]);
            idle_en = (ph != 4);
            if (ph == 3) long_hold_req = 1'b1;
            repeat (70) send_item(make_item(), 1'b0, dummy);
        end
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("[column_scatter_accumulate] OK");
        end else begin
            $display("[column_scatter_accumulate] ERROR");
        end
        $finish;
    end

    initial begin
        csa_pkg::t_out_item want;
        out_ready = 1'b0;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && out_ready) begin
                if (pending_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) $display("unexpected item: %h", o_out_item);
                end else begin
                    want = pending_q.pop_front();
                    if (o_out_item.read_value !== want.read_value ||
                        o_out_item.status !== want.status ||
                        o_out_item.batch_done !== want.batch_done) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: exp val %h st %0d last %0d, got val %h st %0d last %0d",
                                     want.read_value, want.status, want.batch_done,
                                     o_out_item.read_value, o_out_item.status,
                                     o_out_item.batch_done);
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_cnt = 300;
                out_ready <= 1'b0;
            end else begin
                out_ready <= !(idle_en && $urandom_range(99) < 22);
            end
        end
    end

endmodule
